### rtl/assert_macros.svh
// Assertion macros shared by the countdown timer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: expr");

// Checks that a condition implies another one at the next clock edge.
`define ASSERT_NEXT(label, clk, rst_n, cond, nxt) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("assertion failed: cond |=> nxt");

// Checks that a condition implies another one at the same clock edge.
`define ASSERT_SAME(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("assertion failed: cond |-> conseq");

`endif

### rtl/bsct_pkg.sv
// Package with the types and constants of the button-set countdown timer.
package bsct_pkg;

    // Field widths.
    localparam int ADC_W = 10;
    localparam int BTN_W = 3;
    localparam int PH_W = 2;
    localparam int MIN_W = 7;
    localparam int SEC_W = 6;
    localparam int CFG_IDX_W = 4;

    // Limits of the time fields.
    localparam logic [MIN_W-1:0] MAX_MINUTES = 7'd99;
    localparam logic [SEC_W-1:0] SEC_TOP = 6'd59;

    // Button codes.
    localparam logic [BTN_W-1:0] BTN_UP = 3'd0;
    localparam logic [BTN_W-1:0] BTN_DOWN = 3'd1;
    localparam logic [BTN_W-1:0] BTN_LEFT = 3'd2;
    localparam logic [BTN_W-1:0] BTN_SELECT = 3'd3;
    localparam logic [BTN_W-1:0] BTN_NONE = 3'd4;

    // Phase codes.
    localparam logic [PH_W-1:0] PH_MIN = 2'd0;
    localparam logic [PH_W-1:0] PH_SEC = 2'd1;
    localparam logic [PH_W-1:0] PH_COUNT = 2'd2;
    localparam logic [PH_W-1:0] PH_DONE = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_UP = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SELECT = 4'd3;

    // Threshold reset values.
    localparam logic [ADC_W-1:0] RST_UP = 10'd119;
    localparam logic [ADC_W-1:0] RST_DOWN = 10'd276;
    localparam logic [ADC_W-1:0] RST_LEFT = 10'd430;
    localparam logic [ADC_W-1:0] RST_SELECT = 10'd660;

    // One configuration write.
    typedef struct packed {
        logic                 valid;
        logic [CFG_IDX_W-1:0] index;
        logic [ADC_W-1:0]     data;
    } t_cfg_wr;

    // One result item.
    typedef struct packed {
        logic             time_up;
        logic [SEC_W-1:0] seconds;
        logic [MIN_W-1:0] minutes;
        logic [PH_W-1:0]  phase;
        logic [BTN_W-1:0] button;
    } t_result;

endpackage

### rtl/bsct_classify.sv
// Threshold registers and ladder reading classifier.
module bsct_classify (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bsct_pkg::t_cfg_wr           i_cfg,
    input  logic [bsct_pkg::ADC_W-1:0]  i_adc,
    output logic [bsct_pkg::BTN_W-1:0]  o_button
);

    logic [bsct_pkg::ADC_W-1:0] r_up_thr;
    logic [bsct_pkg::ADC_W-1:0] r_down_thr;
    logic [bsct_pkg::ADC_W-1:0] r_left_thr;
    logic [bsct_pkg::ADC_W-1:0] r_select_thr;

    // Threshold register writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_thr     <= bsct_pkg::RST_UP;
            r_down_thr   <= bsct_pkg::RST_DOWN;
            r_left_thr   <= bsct_pkg::RST_LEFT;
            r_select_thr <= bsct_pkg::RST_SELECT;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                bsct_pkg::CFG_UP:     r_up_thr     <= i_cfg.data;
                bsct_pkg::CFG_DOWN:   r_down_thr   <= i_cfg.data;
                bsct_pkg::CFG_LEFT:   r_left_thr   <= i_cfg.data;
                bsct_pkg::CFG_SELECT: r_select_thr <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // The first threshold that the reading falls below wins.
    always_comb begin
        priority if (i_adc < r_up_thr) begin
            o_button = bsct_pkg::BTN_UP;
        end else if (i_adc < r_down_thr) begin
            o_button = bsct_pkg::BTN_DOWN;
        end else if (i_adc < r_left_thr) begin
            o_button = bsct_pkg::BTN_LEFT;
        end else if (i_adc < r_select_thr) begin
            o_button = bsct_pkg::BTN_SELECT;
        end else begin
            o_button = bsct_pkg::BTN_NONE;
        end
    end

endmodule

### rtl/bsct_core.sv
// Phase and mm:ss state of the timer with its next-state logic.
`include "assert_macros.svh"

module bsct_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic                        i_kind,
    input  logic [bsct_pkg::BTN_W-1:0]  i_button,
    output bsct_pkg::t_result           o_result
);

    logic [bsct_pkg::PH_W-1:0]  r_phase;
    logic [bsct_pkg::MIN_W-1:0] r_min;
    logic [bsct_pkg::SEC_W-1:0] r_sec;
    logic [bsct_pkg::PH_W-1:0]  n_phase;
    logic [bsct_pkg::MIN_W-1:0] n_min;
    logic [bsct_pkg::SEC_W-1:0] n_sec;
    logic                       w_time_up;
    logic [bsct_pkg::BTN_W-1:0] w_button;

    // A tick reports no button.
    assign w_button = i_kind ? bsct_pkg::BTN_NONE : i_button;

    // Next state for the item that is being processed.
    always_comb begin
        n_phase   = r_phase;
        n_min     = r_min;
        n_sec     = r_sec;
        w_time_up = 1'b0;
        if (!i_kind) begin
            if (r_phase == bsct_pkg::PH_MIN) begin
                unique case (w_button)
                    bsct_pkg::BTN_UP: begin
                        n_min = (r_min < bsct_pkg::MAX_MINUTES) ? r_min + 7'd1
                                                                : bsct_pkg::MAX_MINUTES;
                    end
                    bsct_pkg::BTN_DOWN: begin
                        if (r_min != '0) begin
                            n_min = r_min - 7'd1;
                        end
                    end
                    bsct_pkg::BTN_SELECT: begin
                        n_phase = bsct_pkg::PH_SEC;
                    end
                    default: ;
                endcase
            end else if (r_phase == bsct_pkg::PH_SEC) begin
                unique case (w_button)
                    bsct_pkg::BTN_UP: begin
                        n_sec = (r_sec >= bsct_pkg::SEC_TOP) ? '0 : r_sec + 6'd1;
                    end
                    bsct_pkg::BTN_DOWN: begin
                        n_sec = (r_sec == '0) ? bsct_pkg::SEC_TOP : r_sec - 6'd1;
                    end
                    bsct_pkg::BTN_SELECT: begin
                        if (r_min == '0 && r_sec == '0) begin
                            n_phase   = bsct_pkg::PH_DONE;
                            w_time_up = 1'b1;
                        end else begin
                            n_phase = bsct_pkg::PH_COUNT;
                        end
                    end
                    default: ;
                endcase
            end
        end else if (r_phase == bsct_pkg::PH_COUNT) begin
            // Count down one second with a borrow from the minutes.
            if (r_sec != '0) begin
                n_sec = r_sec - 6'd1;
            end else if (r_min != '0) begin
                n_sec = bsct_pkg::SEC_TOP;
                n_min = r_min - 7'd1;
            end
            if (n_min == '0 && n_sec == '0) begin
                n_phase   = bsct_pkg::PH_DONE;
                w_time_up = 1'b1;
            end
        end
    end

    // State registers advance once per processed item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= bsct_pkg::PH_MIN;
            r_min   <= '0;
            r_sec   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_min   <= n_min;
            r_sec   <= n_sec;
        end
    end

    assign o_result.button  = w_button;
    assign o_result.phase   = n_phase;
    assign o_result.minutes = n_min;
    assign o_result.seconds = n_sec;
    assign o_result.time_up = w_time_up;

    // Done is final until reset.
    `ASSERT_NEXT(a_done_sticky, i_clk, i_rst_n, r_phase == bsct_pkg::PH_DONE,
        r_phase == bsct_pkg::PH_DONE)
    // Minutes never pass the limit and seconds never pass 59.
    `ASSERT_ALWAYS(a_min_range, i_clk, i_rst_n, r_min <= bsct_pkg::MAX_MINUTES)
    `ASSERT_ALWAYS(a_sec_range, i_clk, i_rst_n, r_sec <= bsct_pkg::SEC_TOP)
    // Time runs out only when the next time is 0:00.
    `ASSERT_SAME(a_time_up_zero, i_clk, i_rst_n, i_step && w_time_up,
        n_min == '0 && n_sec == '0)

endmodule

### rtl/button_set_countdown_timer.sv
// Top level of the button-set minutes:seconds countdown timer.
//
// Input stream (s_axis): one transaction is either a button poll (tuser 0) with a
// settled 10-bit ladder reading in tdata, or a one-second tick (tuser 1).
// Output stream (m_axis): exactly one result transaction per input transaction,
// in order, carrying the classified button, the phase, mm:ss and the time-up flag.
// Configuration channel (i_cfg_*): writes the four button thresholds by index
// 0 up, 1 down, 2 left, 3 select; other indexes are ignored. Write only when idle.
// Path: an accepted input is held in the input register, and its result is written
// to the output register, which presents it on m_axis. Throughput is one transaction
// per cycle while m_axis_tready is high: the classifier and next-state logic between the input
// register and the output register are combinational, and the state updates once.
// Reset (synchronous, active low): thresholds 119/276/430/660, phase set-minutes,
// time 0:00, both pipeline stages empty.
// Stall: when m_axis_tready is low the result holds; one more item can wait in the
// input register before s_axis_tready drops.
`include "assert_macros.svh"

module button_set_countdown_timer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [9:0] adc_value, [15:10] zero
    input  logic        s_axis_tuser,   // [0] kind
    // Output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [2:0] button, [4:3] phase, [11:5] minutes_now,
                                        // [17:12] seconds_now, [18] time_up, [23:19] zero
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data
);

    logic                         r_in_valid;
    logic                         r_in_kind;
    logic [bsct_pkg::ADC_W-1:0]   r_in_adc;
    logic                         r_out_valid;
    bsct_pkg::t_result            r_out;
    logic                         w_adv;
    logic                         w_step;
    logic [bsct_pkg::BTN_W-1:0]   w_button;
    bsct_pkg::t_result            w_result;
    bsct_pkg::t_cfg_wr            w_cfg;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;
    assign w_cfg.valid = i_cfg_valid;
    assign w_cfg.index = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;

    // Pipeline handshake.
    assign w_adv         = !r_out_valid || m_axis_tready;
    assign w_step        = r_in_valid && w_adv;
    assign s_axis_tready = !r_in_valid || w_adv;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_kind <= s_axis_tuser;
            r_in_adc  <= s_axis_tdata[bsct_pkg::ADC_W-1:0];
        end
    end

    bsct_classify u_classify (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_adc    (r_in_adc),
        .o_button (w_button)
    );

    bsct_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_kind   (r_in_kind),
        .i_button (w_button),
        .o_result (w_result)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out};

    // A time-up result always reports the done phase.
    `ASSERT_SAME(a_time_up_done, i_clk, i_rst_n, r_out_valid && r_out.time_up,
        r_out.phase == bsct_pkg::PH_DONE)
    // A held result that is not taken stays valid in the next cycle.
    `ASSERT_NEXT(a_out_held, i_clk, i_rst_n, r_out_valid && !m_axis_tready, r_out_valid)

endmodule

### verif/button_set_countdown_timer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the button-set countdown timer, with a transaction predictor.

import bsct_pkg::*;

// Predicts each result transaction from the accepted input transactions and checks the
// results in order.
class countdown_tracker;
    logic [ADC_W-1:0] thr_up;
    logic [ADC_W-1:0] thr_down;
    logic [ADC_W-1:0] thr_left;
    logic [ADC_W-1:0] thr_select;
    logic [PH_W-1:0]  phase;
    logic [MIN_W-1:0] minutes;
    logic [SEC_W-1:0] seconds;
    t_result          pending_results[$];
    int               errors;

    function new();
        thr_up     = RST_UP;
        thr_down   = RST_DOWN;
        thr_left   = RST_LEFT;
        thr_select = RST_SELECT;
        phase      = PH_MIN;
        minutes    = '0;
        seconds    = '0;
        errors     = 0;
    endfunction

    // Unused indexes leave every threshold alone.
    function void set_threshold(input logic [CFG_IDX_W-1:0] index,
                                input logic [ADC_W-1:0] value);
        case (index)
            CFG_UP:     thr_up = value;
            CFG_DOWN:   thr_down = value;
            CFG_LEFT:   thr_left = value;
            CFG_SELECT: thr_select = value;
            default: ;
        endcase
    endfunction

    // The first threshold that the reading falls below wins.
    function logic [BTN_W-1:0] classify(input logic [ADC_W-1:0] reading);
        if (reading < thr_up) return BTN_UP;
        if (reading < thr_down) return BTN_DOWN;
        if (reading < thr_left) return BTN_LEFT;
        if (reading < thr_select) return BTN_SELECT;
        return BTN_NONE;
    endfunction

    // Advances the timer by one accepted input transaction and queues its result.
    function void accept_item(input logic is_tick, input logic [ADC_W-1:0] reading);
        t_result          res;
        logic [BTN_W-1:0] btn;
        logic             reached;
        btn     = BTN_NONE;
        reached = 1'b0;
        if (!is_tick) begin
            btn = classify(reading);
            if (phase == PH_MIN) begin
                if (btn == BTN_UP)
                    minutes = (minutes < MAX_MINUTES) ? minutes + 1'b1 : MAX_MINUTES;
                else if (btn == BTN_DOWN && minutes != '0)
                    minutes = minutes - 1'b1;
                else if (btn == BTN_SELECT)
                    phase = PH_SEC;
            end else if (phase == PH_SEC) begin
                if (btn == BTN_UP)
                    seconds = (seconds >= SEC_TOP) ? '0 : seconds + 1'b1;
                else if (btn == BTN_DOWN)
                    seconds = (seconds == '0) ? SEC_TOP : seconds - 1'b1;
                else if (btn == BTN_SELECT) begin
                    // Starting at 0:00 finishes at once.
                    if (minutes == '0 && seconds == '0) begin
                        phase   = PH_DONE;
                        reached = 1'b1;
                    end else begin
                        phase = PH_COUNT;
                    end
                end
            end
        end else if (phase == PH_COUNT) begin
            // Count down with a borrow from the minutes.
            if (seconds != '0) begin
                seconds = seconds - 1'b1;
            end else if (minutes != '0) begin
                seconds = SEC_TOP;
                minutes = minutes - 1'b1;
            end
            if (minutes == '0 && seconds == '0) begin
                phase   = PH_DONE;
                reached = 1'b1;
            end
        end
        res.button  = btn;
        res.phase   = phase;
        res.minutes = minutes;
        res.seconds = seconds;
        res.time_up = reached;
        pending_results.push_back(res);
    endfunction

    function void compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Checks one result transaction against the oldest prediction.
    function void check_result(input logic [23:0] data);
        t_result want;
        t_result got;
        if (pending_results.size() == 0) begin
            $error("Result transaction 0x%06h arrived with nothing predicted", data);
            errors++;
            return;
        end
        want = pending_results.pop_front();
        got  = t_result'(data[$bits(t_result)-1:0]);
        compare_field("button", want.button, got.button);
        compare_field("phase", want.phase, got.phase);
        compare_field("minutes_now", want.minutes, got.minutes);
        compare_field("seconds_now", want.seconds, got.seconds);
        compare_field("time_up", want.time_up, got.time_up);
        compare_field("padding", '0, data[23:$bits(t_result)]);
    endfunction
endclass

module button_set_countdown_timer_test;

    localparam int CLK_HALF = 2;
    localparam int TIMEOUT_NS = 1_600_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int SEGMENT_ITEMS = 70;
    localparam logic [ADC_W-1:0] ADC_TOP = '1;
    localparam logic KIND_POLL = 1'b0;
    localparam logic KIND_TICK = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 4'd15;

    typedef enum int {SET_RESET, SET_ZERO, SET_FULL, SET_SCRAMBLED, SET_LADDER} t_threshold_set;
    typedef enum int {READY_ALWAYS, READY_OFTEN, READY_SELDOM} t_ready_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_index = '0;
    logic [9:0]  i_cfg_data = '0;

    countdown_tracker tracker = new();
    int               burst_left = 8;
    t_ready_mode      ready_mode = READY_ALWAYS;
    int               mode_cycles = 0;

    button_set_countdown_timer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Predict on every accepted input transaction and check every accepted result.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                tracker.accept_item(s_axis_tuser, s_axis_tdata[ADC_W-1:0]);
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_result(m_axis_tdata);
        end
    end

    // The receiver switches between always ready, mostly ready and mostly stalled.
    always @(posedge i_clk) begin
        if (mode_cycles == 0) begin
            ready_mode  <= t_ready_mode'($urandom_range(0, 2));
            mode_cycles <= $urandom_range(20, 120);
        end else begin
            mode_cycles <= mode_cycles - 1;
        end
        case (ready_mode)
            READY_ALWAYS: m_axis_tready <= 1'b1;
            READY_OFTEN:  m_axis_tready <= ($urandom_range(0, 3) != 0);
            default:      m_axis_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    // Offers one input transaction and waits until it is taken; bursts end in a short gap.
    task automatic send_item(input logic kind, input logic [ADC_W-1:0] reading);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {{(16 - ADC_W){1'b0}}, reading};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 8);
        end
    endtask

    // Stops sending and waits until every predicted result has come back.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
    endtask

    // One configuration transaction; the caller lowers the valid after the last one.
    task automatic put_reg(input logic [CFG_IDX_W-1:0] index, input logic [ADC_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tracker.set_threshold(index, value);
    endtask

    // Writes all four thresholds, sometimes after a write to an unused index.
    task automatic load_thresholds(input t_threshold_set kind, input logic unused_top);
        logic [ADC_W-1:0] level[4];
        case (kind)
            SET_RESET: level = '{RST_UP, RST_DOWN, RST_LEFT, RST_SELECT};
            SET_ZERO:  level = '{default: '0};
            SET_FULL:  level = '{default: ADC_TOP};
            SET_SCRAMBLED: begin
                foreach (level[i]) level[i] = ADC_W'($urandom_range(0, ADC_TOP));
            end
            default: begin
                // Rising ladder in which every button has a nonempty range.
                level[0] = ADC_W'($urandom_range(1, 200));
                for (int i = 1; i < 4; i++)
                    level[i] = level[i-1] + ADC_W'($urandom_range(1, 200));
            end
        endcase
        if (unused_top)
            put_reg(CFG_UNUSED_HI, ADC_W'($urandom_range(0, ADC_TOP)));
        else if ($urandom_range(0, 2) == 0)
            put_reg(CFG_IDX_W'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)),
                    ADC_W'($urandom_range(0, ADC_TOP)));
        put_reg(CFG_UP, level[0]);
        put_reg(CFG_DOWN, level[1]);
        put_reg(CFG_LEFT, level[2]);
        put_reg(CFG_SELECT, level[3]);
        i_cfg_valid <= 1'b0;
    endtask

    // A random reading that classifies as the given button under the current thresholds,
    // or as none where that button cannot be reached.
    function automatic logic [ADC_W-1:0] reading_for(input logic [BTN_W-1:0] btn);
        int bounds[5];
        int lo;
        int hi;
        bounds[0] = int'(tracker.thr_up);
        bounds[1] = int'(tracker.thr_down);
        bounds[2] = int'(tracker.thr_left);
        bounds[3] = int'(tracker.thr_select);
        bounds[4] = int'(ADC_TOP) + 1;
        lo = 0;
        for (int i = 0; i < int'(btn); i++)
            if (bounds[i] > lo) lo = bounds[i];
        hi = bounds[btn];
        if (lo >= hi) return reading_for(BTN_NONE);
        return ADC_W'($urandom_range(lo, hi - 1));
    endfunction

    task automatic press(input logic [BTN_W-1:0] btn, input int count);
        repeat (count) send_item(KIND_POLL, reading_for(btn));
    endtask

    // One item while a time field is being set; it never selects, so the phase holds.
    task automatic random_setting_item(input int up_weight, input int down_weight);
        logic [ADC_W-1:0] reading;
        int               pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            send_item(KIND_TICK, ADC_W'($urandom_range(0, ADC_TOP)));
        end else if (pick < 25) begin
            reading = ADC_W'($urandom_range(0, ADC_TOP));
            if (tracker.classify(reading) == BTN_SELECT) reading = reading_for(BTN_NONE);
            send_item(KIND_POLL, reading);
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < up_weight) press(BTN_UP, 1);
            else if (pick < up_weight + down_weight) press(BTN_DOWN, 1);
            else if (pick < up_weight + down_weight + 15) press(BTN_LEFT, 1);
            else press(BTN_NONE, 1);
        end
    endtask

    task automatic setting_segment(input t_threshold_set kind, input int up_weight,
                                   input int down_weight, input logic unused_top);
        wait_idle();
        load_thresholds(kind, unused_top);
        repeat (SEGMENT_ITEMS) random_setting_item(up_weight, down_weight);
    endtask

    task automatic steer_minutes(input int target);
        wait_idle();
        if (int'(tracker.minutes) < target) press(BTN_UP, target - int'(tracker.minutes));
        else press(BTN_DOWN, int'(tracker.minutes) - target);
    endtask

    // Main sequence: set minutes, set seconds, count down to zero, then stay done.
    initial begin
        int   target_min;
        int   ticks_left;
        logic zero_start;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Threshold edges under the reset values, down at zero, ticks outside counting.
        send_item(KIND_POLL, '0);
        send_item(KIND_POLL, RST_UP - 1'b1);
        send_item(KIND_POLL, RST_UP);
        send_item(KIND_POLL, RST_DOWN - 1'b1);
        send_item(KIND_POLL, RST_DOWN - 1'b1);
        send_item(KIND_POLL, RST_DOWN);
        send_item(KIND_POLL, RST_LEFT - 1'b1);
        send_item(KIND_POLL, RST_SELECT);
        send_item(KIND_POLL, ADC_TOP);
        send_item(KIND_TICK, ADC_TOP);
        send_item(KIND_TICK, '0);

        // Minutes under extreme, unordered and ordinary thresholds.
        setting_segment(SET_ZERO, 35, 35, 1'b1);
        setting_segment(SET_FULL, 35, 35, 1'b0);
        setting_segment(SET_SCRAMBLED, 35, 35, 1'b0);
        setting_segment(SET_LADDER, 45, 25, 1'b0);
        setting_segment(SET_SCRAMBLED, 35, 35, 1'b0);
        setting_segment(SET_RESET, 35, 35, 1'b0);

        // Drive minutes into the ceiling, wander, then settle on a short countdown.
        wait_idle();
        load_thresholds(SET_LADDER, 1'b0);
        steer_minutes(int'(MAX_MINUTES));
        press(BTN_UP, 4);
        repeat (120) random_setting_item(20, 50);
        zero_start = ($urandom_range(0, 3) == 0);
        target_min = zero_start ? 0 : $urandom_range(0, 3);
        steer_minutes(target_min);

        // Into seconds: down wraps from zero to the top, up wraps back to zero.
        press(BTN_SELECT, 1);
        press(BTN_DOWN, 1);
        press(BTN_UP, 2);
        setting_segment(SET_FULL, 40, 40, 1'b0);
        setting_segment(SET_SCRAMBLED, 40, 40, 1'b0);
        setting_segment(SET_LADDER, 40, 40, 1'b0);

        // Either start at 0:00 or make sure there is time left to count.
        wait_idle();
        load_thresholds(SET_LADDER, 1'b0);
        if (zero_start)
            press(BTN_DOWN, int'(tracker.seconds));
        else if (tracker.minutes == '0 && tracker.seconds == '0)
            press(BTN_UP, 1);
        wait_idle();
        ticks_left = 60 * int'(tracker.minutes) + int'(tracker.seconds);
        press(BTN_SELECT, 1);

        // Count down with ignored polls mixed in.
        wait_idle();
        load_thresholds(SET_SCRAMBLED, 1'b0);
        while (ticks_left > 0) begin
            if ($urandom_range(0, 3) == 0) begin
                send_item(KIND_POLL, ADC_W'($urandom_range(0, ADC_TOP)));
            end else begin
                send_item(KIND_TICK, ADC_W'($urandom_range(0, ADC_TOP)));
                ticks_left--;
            end
        end

        // Once done, nothing moves the timer.
        wait_idle();
        load_thresholds(SET_RESET, 1'b0);
        repeat (40) send_item(1'($urandom_range(0, 1)), ADC_W'($urandom_range(0, ADC_TOP)));

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
